@@ src/deq_pkg.sv @@
`default_nettype none
package deq_pkg;

  // Store geometry. DEPTH must be a power of two: positions wrap by carry-out.
  localparam int DEPTH   = 16;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;

  // Field widths on the ports
  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic exec;     // access the store, move positions and count
    logic load;     // fill the result register
  } deq_cmd_t;

endpackage
`default_nettype wire

@@ src/deq_ctrl.sv @@
`default_nettype none
module deq_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire              out_tready,
  output deq_pkg::deq_cmd_t cmd
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        // wait here while an older result still sits unread
        if (slot_free) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

@@ src/deq_dpath.sv @@
`default_nettype none
module deq_dpath (
  input  wire                             clk,
  input  wire                             rst_n,
  input  deq_pkg::deq_cmd_t               cmd,
  input  wire [deq_pkg::OP_W-1:0]         op_in,
  input  wire [deq_pkg::VALUE_W-1:0]      value_in,
  output logic                            ok_out,
  output logic [deq_pkg::VALUE_W-1:0]     read_value_out,
  output logic [deq_pkg::COUNT_W-1:0]     count_out,
  output logic                            empty_out
);
  import deq_pkg::*;

  logic [DATA_W-1:0]  mem [DEPTH];

  logic [OP_W-1:0]    op_r;
  logic [DATA_W-1:0]  value_r;
  logic [PTR_W-1:0]   front_r, front_nxt;
  logic [PTR_W-1:0]   rear_r, rear_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [DATA_W-1:0]  rd_data_r;
  logic               ok_r, ok_nxt;
  logic               is_read_r, is_read_nxt;

  logic [PTR_W-1:0]   addr;
  logic               wr_en;
  logic               full, empty;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    front_nxt   = front_r;
    rear_nxt    = rear_r;
    count_nxt   = count_r;
    addr        = front_r;
    wr_en       = 1'b0;
    ok_nxt      = 1'b0;
    is_read_nxt = 1'b0;
    case (op_r) inside
      OP_PUSH_FRONT: begin
        addr = front_r - PTR_W'(1);
        if (!full) begin
          front_nxt = addr;
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      OP_PUSH_REAR: begin
        addr = rear_r + PTR_W'(1);
        if (!full) begin
          rear_nxt  = addr;
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        addr        = front_r;
        ok_nxt      = !empty;
        is_read_nxt = 1'b1;
        if (!empty && op_r == OP_POP_FRONT) begin
          front_nxt = front_r + PTR_W'(1);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_POP_REAR, OP_PEEK_REAR: begin
        addr        = rear_r;
        ok_nxt      = !empty;
        is_read_nxt = 1'b1;
        if (!empty && op_r == OP_POP_REAR) begin
          rear_nxt  = rear_r - PTR_W'(1);
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: ;  // unused codes: no operation, fail
    endcase
  end

  // store: one registered read per operation, plus a write on a successful push
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wr_en) begin
        mem[addr] <= value_r;
      end
      rd_data_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= PTR_W'(DEPTH - 1);
      count_r <= '0;
    end else if (cmd.exec) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op_in;
      value_r <= DATA_W'(value_in);
    end
    if (cmd.exec) begin
      ok_r      <= ok_nxt;
      is_read_r <= is_read_nxt;
    end
    if (cmd.load) begin
      ok_out         <= ok_r;
      read_value_out <= (ok_r && is_read_r) ? VALUE_W'(rd_data_r) : '0;
      count_out      <= COUNT_W'(count_r);
      empty_out      <= (count_r == '0);
    end
  end

endmodule
`default_nettype wire

@@ src/double_ended_queue.sv @@
// Bounded double-ended queue over a 16-word circular store.
// Each item passes through the capture / store access / result load sequence of
//   the controller; a new item is accepted only after the last one's result is
//   loaded, and a held result stalls only the load step.
// Reset (rst_n low, synchronous): empty deque, front 0, rear 15, no result
//   pending; store contents stay undefined until pushed.
`default_nettype none
module double_ended_queue (
  input  wire                               clk,
  input  wire                               rst_n,
  // input item
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire [deq_pkg::IN_TDATA_W-1:0]     in_tdata,   // [31:0] push_value
  input  wire [deq_pkg::OP_W-1:0]           in_tuser,   // [2:0] op
  // result item
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [deq_pkg::OUT_TDATA_W-1:0]   out_tdata   // [0] ok, [32:1] read_value,
                                                        // [37:33] count_after,
                                                        // [38] empty_after, [39] zero
);
  import deq_pkg::*;

  deq_cmd_t             cmd;
  logic                 ok;
  logic [VALUE_W-1:0]   read_value;
  logic [COUNT_W-1:0]   count_after;
  logic                 empty_after;

  // Sequence each item: accept, access the store, then hand the result over.
  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Hold the store, the front and rear positions, the count and the result.
  deq_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .op_in          (in_tuser),
    .value_in       (in_tdata),
    .ok_out         (ok),
    .read_value_out (read_value),
    .count_out      (count_after),
    .empty_out      (empty_after)
  );

  // Pack the result fields from the lowest bit up; pad to a whole byte.
  assign out_tdata = {1'b0, empty_after, count_after, read_value, ok};

endmodule
`default_nettype wire
